// ===== rtl/core/rrts_pkg.sv =====
// Package for the round robin thread scheduler: sizes, function and mode codes,
// controller command type and the slot pick functions.
// No dependencies.
package rrts_pkg;

  localparam int THREAD_SLOTS = 4;
  localparam int IDX_W        = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int FIELD_W      = 2;
  localparam int FUNC_W       = 2;
  localparam int MODE_W       = 2;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_EXIT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TIMER  = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_YIELD  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_PREEMPT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COOP    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HYBRID  = 2'd2;

  typedef logic [THREAD_SLOTS-1:0] slot_mask_t;

  typedef struct packed {
    logic found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // Lowest free slot.
  function automatic pick_t lowest_free(input slot_mask_t used);
    pick_t p;
    p = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) begin
        p.found = 1'b1;
        p.idx   = IDX_W'(i);
      end
    end
    return p;
  endfunction

  // Next used slot after the running one, wrapping to the lowest used slot.
  function automatic pick_t next_used(input slot_mask_t used, input logic run_valid,
                                      input logic [IDX_W-1:0] run_slot);
    pick_t hi;
    pick_t any;
    hi  = '0;
    any = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (used[i]) begin
        any.found = 1'b1;
        any.idx   = IDX_W'(i);
        if (run_valid && (IDX_W'(i) > run_slot)) begin
          hi.found = 1'b1;
          hi.idx   = IDX_W'(i);
        end
      end
    end
    return hi.found ? hi : any;
  endfunction

endpackage

// ===== rtl/core/rrts_if.sv =====
// Request and response channel interfaces of the thread scheduler.
// Depends on rrts_pkg.
interface rrts_req_if import rrts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [FIELD_W-1:0] exit_thread;

  modport source (output valid, output func, output exit_thread, input ready);
  modport sink   (input valid, input func, input exit_thread, output ready);
endinterface

interface rrts_rsp_if import rrts_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               create_ok;
  logic [FIELD_W-1:0] new_thread;
  logic               switched;
  logic               saved_valid;
  logic [FIELD_W-1:0] saved_thread;
  logic               current_valid;
  logic [FIELD_W-1:0] current_thread;

  modport source (output valid, output create_ok, output new_thread, output switched,
                  output saved_valid, output saved_thread, output current_valid,
                  output current_thread, input ready);
  modport sink   (input valid, input create_ok, input new_thread, input switched,
                  input saved_valid, input saved_thread, input current_valid,
                  input current_thread, output ready);
endinterface

// ===== rtl/core/rrts_ctrl.sv =====
// Controller of the thread scheduler: load/execute sequence and response valid.
// Depends on rrts_pkg.
module rrts_ctrl import rrts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output logic      rsp_valid,
  input  logic      rsp_ready,
  output ctrl_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;

  // Take a word only when the response register is empty or draining.
  assign req_ready = (state == ST_IDLE) && (!out_valid || rsp_ready);
  assign rsp_valid = out_valid;
  assign cmd.load  = req_valid && req_ready;
  assign cmd.exec  = (state == ST_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec) begin
        out_valid <= 1'b1;
      end else if (rsp_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/rrts_datapath.sv =====
// Datapath of the thread scheduler: slot mask, running thread, mode register,
// pick logic and response register. Depends on rrts_pkg.
module rrts_datapath import rrts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_cmd_t          cmd,
  input  logic               cfg_we,
  input  logic [MODE_W-1:0]  cfg_data,
  input  logic [FUNC_W-1:0]  func,
  input  logic [FIELD_W-1:0] exit_thread,
  output logic               create_ok,
  output logic [FIELD_W-1:0] new_thread,
  output logic               switched,
  output logic               saved_valid,
  output logic [FIELD_W-1:0] saved_thread,
  output logic               current_valid,
  output logic [FIELD_W-1:0] current_thread
);

  logic [MODE_W-1:0]  sched_mode;
  slot_mask_t         slot_used;
  logic [IDX_W-1:0]   running_slot;
  logic               running_valid;
  logic [FUNC_W-1:0]  func_q;
  logic [FIELD_W-1:0] exit_q;

  slot_mask_t         slot_used_next;
  logic [IDX_W-1:0]   running_slot_next;
  logic               running_valid_next;
  logic               ok_next;
  logic [IDX_W-1:0]   nt_next;
  logic               sw_next;
  logic               sv_next;
  logic [IDX_W-1:0]   st_next;
  logic               do_switch;
  slot_mask_t         used_eff;
  pick_t              free_pick;
  pick_t              run_pick;

  always_comb begin
    used_eff = slot_used;
    if ((func_q == FUNC_EXIT) && (32'(exit_q) < THREAD_SLOTS)) begin
      used_eff[IDX_W'(exit_q)] = 1'b0;
    end
  end

  assign free_pick = lowest_free(slot_used);
  assign run_pick  = next_used(used_eff, running_valid, running_slot);

  always_comb begin
    case (func_q)
      FUNC_CREATE: do_switch = 1'b0;
      FUNC_EXIT:   do_switch = 1'b1;
      FUNC_TIMER:  do_switch = (sched_mode != MODE_COOP);
      FUNC_YIELD:  do_switch = (sched_mode != MODE_PREEMPT);
      default:     do_switch = 1'b0;
    endcase
  end

  always_comb begin
    slot_used_next     = used_eff;
    running_slot_next  = running_slot;
    running_valid_next = running_valid;
    ok_next            = 1'b0;
    nt_next            = '0;
    sw_next            = 1'b0;
    sv_next            = 1'b0;
    st_next            = '0;
    if (func_q == FUNC_CREATE) begin
      if (free_pick.found) begin
        slot_used_next[free_pick.idx] = 1'b1;
        ok_next = 1'b1;
        nt_next = free_pick.idx;
      end
    end else if (do_switch) begin
      if (!running_valid) begin
        if (run_pick.found) begin
          running_slot_next  = run_pick.idx;
          running_valid_next = 1'b1;
          sw_next            = 1'b1;
        end
      end else if (!(run_pick.found && (run_pick.idx == running_slot))) begin
        sw_next = 1'b1;
        sv_next = 1'b1;
        st_next = running_slot;
        // Last used slot gone: drop to no running thread.
        running_slot_next  = run_pick.found ? run_pick.idx : '0;
        running_valid_next = run_pick.found;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sched_mode    <= MODE_PREEMPT;
      slot_used     <= '0;
      running_slot  <= '0;
      running_valid <= 1'b0;
    end else begin
      if (cfg_we) sched_mode <= cfg_data;
      if (cmd.exec) begin
        slot_used     <= slot_used_next;
        running_slot  <= running_slot_next;
        running_valid <= running_valid_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q <= func;
      exit_q <= exit_thread;
    end
    if (cmd.exec) begin
      create_ok      <= ok_next;
      new_thread     <= FIELD_W'(nt_next);
      switched       <= sw_next;
      saved_valid    <= sv_next;
      saved_thread   <= FIELD_W'(st_next);
      current_valid  <= running_valid_next;
      current_thread <= running_valid_next ? FIELD_W'(running_slot_next) : '0;
    end
  end

endmodule

// ===== rtl/core/round_robin_thread_scheduler_unit.sv =====
// Top level of the round robin thread scheduler: controller plus datapath.
// Depends on rrts_pkg, rrts_if, rrts_ctrl and rrts_datapath.
//
//   channel  direction  handshake        word
//   req      in         valid/ready      func, exit_thread
//   rsp      out        valid/ready      create_ok .. current_thread
//   cfg      in         cfg_we           cfg_data (sched_mode)
//
// Each word is first loaded from the request, then picked and applied to state
// in the controller's execute state; its load/execute sequence sets this order.
// Reset clears the slot mask, the running thread, the mode and the response valid.
// A result waits in the response register; the next word is taken once that
// register is empty or drained in the same cycle.
module round_robin_thread_scheduler_unit import rrts_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_data,
  rrts_req_if.sink          req,
  rrts_rsp_if.source        rsp
);

  ctrl_cmd_t cmd;

  rrts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  rrts_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_we         (cfg_we),
    .cfg_data       (cfg_data),
    .func           (req.func),
    .exit_thread    (req.exit_thread),
    .create_ok      (rsp.create_ok),
    .new_thread     (rsp.new_thread),
    .switched       (rsp.switched),
    .saved_valid    (rsp.saved_valid),
    .saved_thread   (rsp.saved_thread),
    .current_valid  (rsp.current_valid),
    .current_thread (rsp.current_thread)
  );

endmodule
